### rtl/ovl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_pkg: shared types for the ordered value list
// Operation codes, request and result payloads, and the per-cell record.
// ----------------------------------------------------------------------------
package ovl_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_ORDERED = 3'd1,
    OP_QUERY        = 3'd2,
    OP_REMOVE       = 3'd3,
    OP_CLEAR        = 3'd4
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       accepted;
    logic       is_empty;
    logic [4:0] entry_count;
  } rsp_t;

  // Contents of one cell: occupied flag and stored value.
  typedef struct packed {
    logic               occ;
    logic signed [31:0] entry;
  } slot_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic               go;
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

  // Flags that ripple from the front of the row toward the back.
  typedef struct packed {
    logic hit;
    logic stop;
  } chain_t;

endpackage : ovl_pkg
`default_nettype wire

### rtl/ovl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_cell: one position of the list
// Holds one entry, compares it with the request value and shifts with its
// neighbors on inserts and removes.
// ----------------------------------------------------------------------------
module ovl_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ovl_pkg::cmd_t         cmd_i,
  input  ovl_pkg::slot_t        left_i,
  input  ovl_pkg::slot_t        right_i,
  input  ovl_pkg::chain_t       chain_i,
  output ovl_pkg::chain_t       chain_o,
  output ovl_pkg::slot_t        slot_o
);
  import ovl_pkg::*;

  logic               occ_q, occ_d;
  logic signed [31:0] entry_q, entry_d;
  logic               match;
  logic               stop;

  assign match = occ_q && (entry_q == cmd_i.value);
  // The ordered insert lands in the first free cell or before the first
  // entry that is not smaller than the new value.
  assign stop  = !occ_q || !(entry_q < cmd_i.value);

  assign chain_o.hit  = chain_i.hit | match;
  assign chain_o.stop = chain_i.stop | stop;
  assign slot_o.occ   = occ_q;
  assign slot_o.entry = entry_q;

  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    if (cmd_i.go) begin
      case (cmd_i.op)
        OP_PUSH_FRONT: begin
          occ_d   = left_i.occ;
          entry_d = left_i.entry;
        end
        OP_PUSH_ORDERED: begin
          if (chain_i.stop) begin
            occ_d   = left_i.occ;
            entry_d = left_i.entry;
          end else if (stop) begin
            occ_d   = 1'b1;
            entry_d = cmd_i.value;
          end
        end
        OP_REMOVE: begin
          if (chain_i.hit || match) begin
            occ_d   = right_i.occ;
            entry_d = right_i.entry;
          end
        end
        OP_CLEAR: begin
          occ_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule : ovl_cell
`default_nettype wire

### rtl/ordered_value_list.sv
`timescale 1ns / 1ps
`default_nettype none
// The result strobe is registered and rises in the cycle after a request is taken.
// One request per cycle is taken; busy never rises, since every cell
// compares and shifts with its neighbors in the same cycle.
// The first-match and insert-position flags ripple through all CAPACITY cells.
// Reset clears the occupied flags and the count; the list starts empty.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// ordered_value_list: bounded list of signed 32-bit values
// A row of cells, front at cell 0, supporting front and ordered insert,
// membership query, remove of the first match and clear.
// ----------------------------------------------------------------------------
module ordered_value_list #(
  parameter int CAPACITY = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  ovl_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output ovl_pkg::rsp_t rsp_o
);
  import ovl_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic            take;
  logic            full;
  logic            is_insert;
  logic            [CntW-1:0] count_q, count_d;
  logic            rsp_valid_q;
  rsp_t            rsp_q, rsp_d;
  cmd_t            cmd;
  slot_t           slots    [CAPACITY];
  slot_t           lefts    [CAPACITY];
  slot_t           rights   [CAPACITY];
  chain_t          chains   [CAPACITY+1];
  logic [CAPACITY-1:0] occ_vec;

  assign busy      = 1'b0;
  assign take      = start && !busy;
  assign full      = (count_q == CntW'(CAPACITY));
  assign is_insert = (req_i.operation == OP_PUSH_FRONT) ||
                     (req_i.operation == OP_PUSH_ORDERED);

  assign cmd.go    = take && !(is_insert && full);
  assign cmd.op    = req_i.operation;
  assign cmd.value = req_i.value;

  assign chains[0] = '{hit: 1'b0, stop: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_front
      // The front cell pulls the new value in on a front insert.
      assign lefts[i] = '{occ: 1'b1, entry: req_i.value};
    end else begin : g_mid
      assign lefts[i] = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign rights[i] = '{occ: 1'b0, entry: '0};
    end else begin : g_inner
      assign rights[i] = slots[i+1];
    end
    assign occ_vec[i] = slots[i].occ;

    ovl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (lefts[i]),
      .right_i (rights[i]),
      .chain_i (chains[i]),
      .chain_o (chains[i+1]),
      .slot_o  (slots[i])
    );
  end

  always_comb begin
    count_d          = count_q;
    rsp_d.found      = 1'b0;
    rsp_d.accepted   = 1'b0;
    case (req_i.operation)
      OP_PUSH_FRONT, OP_PUSH_ORDERED: begin
        if (!full) begin
          count_d        = count_q + CntW'(1);
          rsp_d.accepted = 1'b1;
        end
      end
      OP_QUERY: begin
        rsp_d.found = chains[CAPACITY].hit;
      end
      OP_REMOVE: begin
        if (chains[CAPACITY].hit) begin
          count_d     = count_q - CntW'(1);
          rsp_d.found = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The occupied cells always form an unbroken run from the front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_vec & ~{occ_vec[CAPACITY-2:0], 1'b1}) == '0)
    else $error("occupied cells not contiguous from the front");

  // The count tracks the number of occupied cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(count_q))
    else $error("count disagrees with occupied cells");

  // An accepted insert grows the list by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.accepted |-> count_q == CntW'($past(count_q) + 1))
    else $error("accepted insert did not grow the list by one");

  // Every request taken produces a result strobe in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> rsp_valid_q)
    else $error("result strobe missing after a request");

endmodule : ordered_value_list
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered value list
// A queue of requests feeds a clocked driver. Each accepted request is run
// through a local model of the list, and the predicted response is queued.
// A clocked monitor compares every response strobe with the oldest
// prediction. The requests start with directed cases: extremes, every
// operation, a full list and the spare codes. Random phases follow that
// fill, drain, sort and scramble the list.
// ----------------------------------------------------------------------------
module tb_top;
  import ovl_pkg::*;

  localparam int          LIST_DEPTH   = 16;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          POOL_SIZE    = 24;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] VAL_NEG_ONE  = 32'hffff_ffff;
  localparam logic [2:0]  OP_SPARE_5   = 3'd5;
  localparam logic [2:0]  OP_SPARE_6   = 3'd6;
  localparam logic [2:0]  OP_SPARE_7   = 3'd7;

  typedef struct {
    req_t req;
    bit   may_idle;
    bit   wait_drain;
  } pending_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic rsp_valid_o;
  rsp_t rsp_o;

  pending_req_t        pending_q[$];
  rsp_t                want_rsp_q[$];
  logic signed [31:0]  list_val[LIST_DEPTH];
  int                  list_len = 0;
  int unsigned         fail_cnt = 0;
  logic [31:0]         value_pool[POOL_SIZE];

  ordered_value_list #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Applies one request to the local copy of the list and returns the
  // response the block should give for it.
  function automatic rsp_t predict_list_op(req_t r);
    rsp_t res;
    int   hit;
    int   pos;
    int   i;
    res = '0;
    hit = -1;
    for (i = 0; i < list_len; i++) begin
      if (hit < 0 && list_val[i] == r.value) hit = i;
    end
    case (r.operation)
      OP_PUSH_FRONT, OP_PUSH_ORDERED: begin
        if (list_len < LIST_DEPTH) begin
          pos = 0;
          if (r.operation == OP_PUSH_ORDERED) begin
            while (pos < list_len && list_val[pos] < r.value) pos++;
          end
          for (i = list_len; i > pos; i--) list_val[i] = list_val[i-1];
          list_val[pos] = r.value;
          list_len++;
          res.accepted = 1'b1;
        end
      end
      OP_QUERY: begin
        res.found = (hit >= 0);
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < list_len; i++) list_val[i] = list_val[i+1];
          list_len--;
          res.found = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: ;
    endcase
    res.is_empty    = (list_len == 0);
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  task automatic add_req(input logic [2:0] code, input logic [31:0] v,
                         input bit may_idle, input bit wait_drain);
    pending_req_t p;
    p.req        = req_t'({code, v});
    p.may_idle   = may_idle;
    p.wait_drain = wait_drain;
    pending_q.push_back(p);
  endtask

  // Most values come from a small pool so that lookups and removes hit.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) < 7) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin : drive_reqs
    bit           send;
    pending_req_t nxt;
    if (rst_ni) begin
      if (start && !busy) want_rsp_q.push_back(predict_list_op(req_i));
      if (!start || !busy) begin
        send = 1'b0;
        if (pending_q.size() != 0) begin
          nxt  = pending_q[0];
          send = 1'b1;
          if (nxt.wait_drain && want_rsp_q.size() != 0) begin
            send = 1'b0;
          end else if (nxt.may_idle && $urandom_range(99) < 19) begin
            send = 1'b0;
          end
        end
        if (send) begin
          req_i <= nxt.req;
          void'(pending_q.pop_front());
        end
        start <= send;
      end
    end
  end

  always @(posedge clk_i) begin : check_rsps
    rsp_t want;
    if (rst_ni) begin
      if ($isunknown(rsp_valid_o)) begin
        note_mismatch("rsp_valid_o", 32'd0, 32'(rsp_valid_o));
      end else if (rsp_valid_o) begin
        if (want_rsp_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %p", $time, rsp_o);
          fail_cnt++;
        end else begin
          want = want_rsp_q.pop_front();
          if (rsp_o.found !== want.found) begin
            note_mismatch("found", 32'(want.found), 32'(rsp_o.found));
          end
          if (rsp_o.accepted !== want.accepted) begin
            note_mismatch("accepted", 32'(want.accepted), 32'(rsp_o.accepted));
          end
          if (rsp_o.is_empty !== want.is_empty) begin
            note_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_o.is_empty));
          end
          if (rsp_o.entry_count !== want.entry_count) begin
            note_mismatch("entry_count", 32'(want.entry_count), 32'(rsp_o.entry_count));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int          total;
    int          kind;
    int          len;
    int          j;
    int          r;
    int          quiet_lo;
    logic [2:0]  code;
    logic [31:0] v;
    bit          hold;

    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = VAL_NEG_ONE;
    value_pool[4] = 32'd1;
    for (j = 5; j < POOL_SIZE; j++) begin
      if (j % 2 == 0) value_pool[j] = $urandom;
      else value_pool[j] = 32'($signed($urandom_range(40)) - 20);
    end

    // Empty list cases and a spare code.
    add_req(OP_CLEAR, $urandom, 1, 0);
    add_req(OP_QUERY, '0, 1, 0);
    add_req(OP_REMOVE, 32'd7, 1, 0);
    add_req(OP_SPARE_5, VAL_MAX, 1, 0);
    // Sixteen inserts fill the list, mixing extremes, duplicates and order.
    add_req(OP_PUSH_FRONT, VAL_MIN, 1, 0);
    add_req(OP_PUSH_FRONT, VAL_MAX, 1, 0);
    add_req(OP_PUSH_ORDERED, '0, 1, 0);
    add_req(OP_PUSH_ORDERED, VAL_NEG_ONE, 1, 0);
    add_req(OP_PUSH_ORDERED, VAL_MIN, 1, 0);
    add_req(OP_PUSH_ORDERED, VAL_MAX, 1, 0);
    add_req(OP_PUSH_ORDERED, '0, 1, 0);
    add_req(OP_PUSH_FRONT, 32'd5, 1, 0);
    add_req(OP_PUSH_ORDERED, 32'd5, 1, 0);
    add_req(OP_PUSH_ORDERED, -32'sd7, 1, 0);
    add_req(OP_PUSH_FRONT, VAL_NEG_ONE, 1, 0);
    add_req(OP_PUSH_ORDERED, 32'd100, 1, 0);
    add_req(OP_PUSH_ORDERED, -32'sd100, 1, 0);
    add_req(OP_PUSH_FRONT, '0, 1, 0);
    add_req(OP_PUSH_ORDERED, 32'd3, 1, 0);
    add_req(OP_PUSH_ORDERED, 32'd42, 1, 0);
    // The list is full now, so both inserts must be refused.
    add_req(OP_PUSH_FRONT, 32'd9, 1, 0);
    add_req(OP_PUSH_ORDERED, 32'd9, 1, 0);
    add_req(OP_QUERY, VAL_MAX, 1, 0);
    add_req(OP_QUERY, 32'd12345, 1, 0);
    add_req(OP_REMOVE, '0, 1, 0);
    add_req(OP_REMOVE, 32'd777, 1, 0);
    add_req(OP_SPARE_6, VAL_NEG_ONE, 1, 0);
    add_req(OP_SPARE_7, '0, 1, 0);
    add_req(OP_QUERY, VAL_MIN, 1, 0);
    add_req(OP_CLEAR, VAL_NEG_ONE, 1, 0);

    // Random phases; one window of requests is sent without random idle gaps.
    total    = 0;
    quiet_lo = $urandom_range(250, 400);
    while (total < RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      len  = $urandom_range(12, 36);
      hold = (total == 0) || ($urandom_range(3) == 0);
      for (j = 0; j < len; j++) begin
        r = $urandom_range(99);
        v = pick_value();
        case (kind)
          0, 1, 2, 3: begin
            if (r < 40) code = OP_PUSH_FRONT;
            else if (r < 80) code = OP_PUSH_ORDERED;
            else if (r < 90) code = OP_QUERY;
            else code = OP_REMOVE;
          end
          4, 5, 6: begin
            if (r < 55) code = OP_REMOVE;
            else if (r < 85) code = OP_QUERY;
            else if (r < 95) code = OP_PUSH_ORDERED;
            else code = OP_PUSH_FRONT;
          end
          7: begin
            code = 3'($urandom_range(7));
            if (r < 50) v = $urandom;
          end
          8: begin
            code = (r < 70) ? OP_PUSH_ORDERED : OP_QUERY;
          end
          default: begin
            if (j == 0) code = OP_CLEAR;
            else if (r < 60) code = OP_PUSH_ORDERED;
            else if (r < 80) code = OP_PUSH_FRONT;
            else code = OP_QUERY;
          end
        endcase
        add_req(code, v, !(total >= quiet_lo && total < quiet_lo + 150), hold && j == 0);
        total++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || want_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
rtl/ovl_pkg.sv
rtl/ovl_cell.sv
rtl/ordered_value_list.sv
sim/tb_top.sv
